### sv/square_wave_channel_with_sweep_core_defines.svh
// Assertion macros used by the square-wave channel top-level RTL.
`ifndef SQUARE_WAVE_CHANNEL_WITH_SWEEP_CORE_DEFINES_SVH
`define SQUARE_WAVE_CHANNEL_WITH_SWEEP_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define SWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define SWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/swc_pkg.sv
// Shared types, codes, constants and helper functions of the square-wave channel.
`default_nettype none
package swc_pkg;

  localparam int PERIOD_SCALE = 4;
  localparam int FREQ_W       = 11;
  localparam int PERIOD_W     = $clog2(2048 * PERIOD_SCALE + 1);
  localparam int LEN_W        = 7;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;

  localparam logic [LEN_W-1:0]  LEN_FULL  = 7'd64;
  localparam logic [3:0]        VOL_MAX   = 4'hF;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FRAME = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_SWEEP   = 3'd0,
    SEL_DUTY    = 3'd1,
    SEL_ENV     = 3'd2,
    SEL_FREQ_LO = 3'd3,
    SEL_FREQ_HI = 3'd4
  } reg_sel_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [2:0] frame_step;
  } req_t;

  typedef struct packed {
    logic [3:0]        amplitude;
    logic              channel_on;
    logic [FREQ_W-1:0] frequency_now;
    logic [LEN_W-1:0]  length_left;
  } res_t;

  typedef struct packed {
    logic [FREQ_W:0] sum;
    logic            overflow;
  } sweep_res_t;

  // Bit i of a row is duty step i.
  localparam logic [7:0] DUTY_TABLE [4] = '{
    8'b1000_0000,
    8'b1000_0001,
    8'b1110_0001,
    8'b0111_1110
  };

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] row;
    row = DUTY_TABLE[sel];
    return row[pos];
  endfunction

  function automatic logic [PERIOD_W-1:0] period_reload(input logic [FREQ_W-1:0] f);
    logic [FREQ_W:0] diff;
    diff = 12'd2048 - {1'b0, f};
    return PERIOD_W'(diff * PERIOD_SCALE);
  endfunction

  // Shift and add or subtract; overflow when the unmasked sum passes 2047.
  function automatic sweep_res_t sweep_calc(input logic [FREQ_W-1:0] shadow,
                                            input logic [2:0] shift,
                                            input logic negate);
    sweep_res_t r;
    logic [FREQ_W-1:0] delta;
    delta = shadow >> shift;
    if (negate) begin
      r.sum = {1'b0, shadow} - {1'b0, delta};
    end else begin
      r.sum = {1'b0, shadow} + {1'b0, delta};
    end
    r.overflow = r.sum[FREQ_W];
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/square_wave_channel_with_sweep_core.sv
// Accepted requests enter the input register; results are held in the output register.
// Throughput: one request per cycle; the input register and the channel state
// update form a single pass, so a new request enters every cycle while m_tready is high.
// A result waiting in the output register still lets the input register fill.
// Reset: synchronous rst clears both stage valid bits and every channel register.
`default_nettype none
`include "square_wave_channel_with_sweep_core_defines.svh"
module square_wave_channel_with_sweep_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata: reg_select [2:0], write_data [10:3], frame_step [13:11], zero [15:14]
  input  wire logic [swc_pkg::IN_DATA_W-1:0]      s_tdata,
  // s_tuser: command [1:0]
  input  wire logic [1:0]                         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata: amplitude [3:0], channel_on [4], frequency_now [15:5],
  //          length_left [22:16], zero [23]
  output logic [swc_pkg::OUT_DATA_W-1:0]          m_tdata
);

  logic          in_valid;
  swc_pkg::req_t in_req;
  logic          out_valid;
  swc_pkg::res_t out_res;
  swc_pkg::res_t res;
  logic          advance;
  logic          step;

  // Move the input stage forward whenever the output register is free or drains.
  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  swc_channel u_channel (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (in_req),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  // Capture the request payload and the result of each step; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.command    <= s_tuser;
      in_req.reg_select <= s_tdata[2:0];
      in_req.write_data <= s_tdata[10:3];
      in_req.frame_step <= s_tdata[13:11];
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.length_left, out_res.frequency_now,
                     out_res.channel_on, out_res.amplitude};

  `SWC_ASSERT_NOW(a_ready_when_empty, !in_valid, s_tready,
    "input stage empty but not ready")
  `SWC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, in_valid,
    "accepted request did not reach the input stage")
  `SWC_ASSERT_NEXT(a_step_fills_out, step, out_valid,
    "processed request did not reach the output register")
  `SWC_ASSERT_NOW(a_length_range, out_valid, out_res.length_left <= swc_pkg::LEN_FULL,
    "length count above full length")
  `SWC_ASSERT_NOW(a_silent_when_off, out_valid && !out_res.channel_on,
    out_res.amplitude == 4'd0, "amplitude nonzero while channel off")

endmodule
`default_nettype wire

### sv/swc_channel.sv
// Channel state registers with the per-request update of timer, sweep, envelope and length.
`default_nettype none
module swc_channel (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire swc_pkg::req_t req,
  output swc_pkg::res_t      res
);

  logic [6:0]                    sweep_reg,      sweep_reg_next;
  logic [1:0]                    duty_select,    duty_select_next;
  logic [7:0]                    envelope_reg,   envelope_reg_next;
  logic [swc_pkg::FREQ_W-1:0]    freq_reg,       freq_reg_next;
  logic                          length_enable,  length_enable_next;
  logic [swc_pkg::LEN_W-1:0]     length_count,   length_count_next;
  logic [swc_pkg::PERIOD_W-1:0]  period_count,   period_count_next;
  logic [2:0]                    duty_position,  duty_position_next;
  logic [3:0]                    volume_now,     volume_now_next;
  logic [2:0]                    envelope_count, envelope_count_next;
  logic [swc_pkg::FREQ_W-1:0]    shadow_freq,    shadow_freq_next;
  logic [3:0]                    sweep_count,    sweep_count_next;
  logic chan_on,  chan_on_next;
  logic sweep_on, sweep_on_next;
  logic env_on,   env_on_next;
  logic neg_used, neg_used_next;
  logic prev_len, prev_len_next;
  logic prev_swp, prev_swp_next;
  logic prev_env, prev_env_next;

  always_comb begin
    swc_pkg::sweep_res_t c1;
    swc_pkg::sweep_res_t c2;
    logic [swc_pkg::FREQ_W-1:0] f_new;
    logic [3:0] vol_init;
    logic [swc_pkg::LEN_W-1:0] len_dec;
    logic [3:0] swc_dec;
    logic [2:0] env_dec;
    logic lb, sb, eb;

    sweep_reg_next      = sweep_reg;
    duty_select_next    = duty_select;
    envelope_reg_next   = envelope_reg;
    freq_reg_next       = freq_reg;
    length_enable_next  = length_enable;
    length_count_next   = length_count;
    period_count_next   = period_count;
    duty_position_next  = duty_position;
    volume_now_next     = volume_now;
    envelope_count_next = envelope_count;
    shadow_freq_next    = shadow_freq;
    sweep_count_next    = sweep_count;
    chan_on_next        = chan_on;
    sweep_on_next       = sweep_on;
    env_on_next         = env_on;
    neg_used_next       = neg_used;
    prev_len_next       = prev_len;
    prev_swp_next       = prev_swp;
    prev_env_next       = prev_env;

    f_new    = {req.write_data[2:0], freq_reg[7:0]};
    vol_init = envelope_reg[7:4];
    c1       = swc_pkg::sweep_calc(shadow_freq, sweep_reg[2:0], sweep_reg[3]);
    c2       = swc_pkg::sweep_calc(c1.sum[swc_pkg::FREQ_W-1:0], sweep_reg[2:0],
                                   sweep_reg[3]);
    len_dec  = length_count - 7'd1;
    swc_dec  = (sweep_count != 4'd0) ? sweep_count - 4'd1 : 4'd0;
    env_dec  = (envelope_count != 3'd0) ? envelope_count - 3'd1 : 3'd0;
    lb       = req.frame_step[0];
    sb       = req.frame_step[1];
    eb       = req.frame_step[2];

    unique case (req.command)
      swc_pkg::CMD_WRITE: begin
        unique case (req.reg_select)
          swc_pkg::SEL_SWEEP: begin
            sweep_reg_next = req.write_data[6:0];
            if (req.write_data[6:4] == 3'd0 || req.write_data[2:0] == 3'd0 ||
                (!req.write_data[3] && neg_used)) begin
              sweep_on_next = 1'b0;
            end
          end
          swc_pkg::SEL_DUTY: begin
            duty_select_next  = req.write_data[7:6];
            length_count_next = swc_pkg::LEN_FULL - {1'b0, req.write_data[5:0]};
          end
          swc_pkg::SEL_ENV: begin
            envelope_reg_next = req.write_data;
          end
          swc_pkg::SEL_FREQ_LO: begin
            freq_reg_next = {freq_reg[10:8], req.write_data};
          end
          swc_pkg::SEL_FREQ_HI: begin
            freq_reg_next      = f_new;
            length_enable_next = req.write_data[6];
            if (req.write_data[7]) begin
              // Trigger: restart timer, sweep and envelope, and reload an exhausted length.
              c1 = swc_pkg::sweep_calc(f_new, sweep_reg[2:0], sweep_reg[3]);
              period_count_next   = swc_pkg::period_reload(f_new);
              shadow_freq_next    = f_new;
              sweep_count_next    = {1'b0, sweep_reg[6:4]};
              sweep_on_next       = (sweep_reg[6:4] != 3'd0) && (sweep_reg[2:0] != 3'd0);
              chan_on_next        = 1'b1;
              if (sweep_reg[2:0] != 3'd0 && c1.overflow) begin
                sweep_on_next = 1'b0;
                chan_on_next  = 1'b0;
              end
              neg_used_next       = 1'b0;
              volume_now_next     = vol_init;
              envelope_count_next = envelope_reg[2:0];
              env_on_next = (envelope_reg[2:0] != 3'd0) &&
                            !((!envelope_reg[3] && vol_init == 4'd0) ||
                              (envelope_reg[3] && vol_init == swc_pkg::VOL_MAX));
              if (length_count == '0) begin
                length_count_next = swc_pkg::LEN_FULL;
              end
              if (vol_init == 4'd0) begin
                chan_on_next = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      swc_pkg::CMD_TICK: begin
        if (period_count == '0) begin
          duty_position_next = duty_position + 3'd1;
          period_count_next  = swc_pkg::period_reload(freq_reg);
        end else begin
          period_count_next = period_count - {{(swc_pkg::PERIOD_W-1){1'b0}}, 1'b1};
        end
      end
      swc_pkg::CMD_FRAME: begin
        // Length clock on a falling edge of bit 0.
        if (length_enable && length_count != '0 && !lb && prev_len) begin
          length_count_next = len_dec;
          if (len_dec == '0) begin
            chan_on_next = 1'b0;
          end
        end
        prev_len_next = lb;

        // Sweep clock on a falling edge of bit 1.
        if (sweep_on && !sb && prev_swp) begin
          sweep_count_next = swc_dec;
          if (swc_dec == 4'd0) begin
            if (sweep_reg[3]) begin
              neg_used_next = 1'b1;
            end
            if (c1.overflow) begin
              sweep_on_next = 1'b0;
              chan_on_next  = 1'b0;
            end else if (sweep_reg[2:0] != 3'd0) begin
              shadow_freq_next = c1.sum[swc_pkg::FREQ_W-1:0];
              freq_reg_next    = c1.sum[swc_pkg::FREQ_W-1:0];
              if (c2.overflow) begin
                sweep_on_next = 1'b0;
                chan_on_next  = 1'b0;
              end
            end
            sweep_count_next = {1'b0, sweep_reg[6:4]} + 4'd1;
          end
        end
        prev_swp_next = sb;

        // Envelope clock on a falling edge of bit 2.
        if (env_on && chan_on_next && !eb && prev_env) begin
          envelope_count_next = env_dec;
          if (env_dec == 3'd0) begin
            if (!envelope_reg[3]) begin
              if (volume_now != 4'd0) begin
                volume_now_next = volume_now - 4'd1;
              end
              if (volume_now <= 4'd1) begin
                env_on_next = 1'b0;
              end
            end else begin
              if (volume_now != swc_pkg::VOL_MAX) begin
                volume_now_next = volume_now + 4'd1;
              end
              if (volume_now >= swc_pkg::VOL_MAX - 4'd1) begin
                env_on_next = 1'b0;
              end
            end
            envelope_count_next = envelope_reg[2:0];
            if (envelope_reg[2:0] == 3'd0) begin
              env_on_next = 1'b0;
            end
          end
        end
        prev_env_next = eb;
      end
      default: begin
      end
    endcase
  end

  // Show the channel as it stands after this request.
  always_comb begin
    res.channel_on    = chan_on_next;
    res.amplitude     = (chan_on_next && swc_pkg::duty_bit(duty_select_next,
                         duty_position_next)) ? volume_now_next : 4'd0;
    res.frequency_now = freq_reg_next;
    res.length_left   = length_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_reg      <= '0;
      duty_select    <= '0;
      envelope_reg   <= '0;
      freq_reg       <= '0;
      length_enable  <= 1'b0;
      length_count   <= '0;
      period_count   <= '0;
      duty_position  <= '0;
      volume_now     <= '0;
      envelope_count <= '0;
      shadow_freq    <= '0;
      sweep_count    <= '0;
      chan_on        <= 1'b0;
      sweep_on       <= 1'b0;
      env_on         <= 1'b0;
      neg_used       <= 1'b0;
      prev_len       <= 1'b0;
      prev_swp       <= 1'b0;
      prev_env       <= 1'b0;
    end else if (step) begin
      sweep_reg      <= sweep_reg_next;
      duty_select    <= duty_select_next;
      envelope_reg   <= envelope_reg_next;
      freq_reg       <= freq_reg_next;
      length_enable  <= length_enable_next;
      length_count   <= length_count_next;
      period_count   <= period_count_next;
      duty_position  <= duty_position_next;
      volume_now     <= volume_now_next;
      envelope_count <= envelope_count_next;
      shadow_freq    <= shadow_freq_next;
      sweep_count    <= sweep_count_next;
      chan_on        <= chan_on_next;
      sweep_on       <= sweep_on_next;
      env_on         <= env_on_next;
      neg_used       <= neg_used_next;
      prev_len       <= prev_len_next;
      prev_swp       <= prev_swp_next;
      prev_env       <= prev_env_next;
    end
  end

endmodule
`default_nettype wire

### tb/sv/swc_channel_checker.sv
// Checker for the square-wave channel: watches both streams, predicts and compares.
module swc_channel_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [swc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [1:0]                     s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [swc_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Bit i of a row is the level at duty step i.
  localparam logic [7:0] DUTY_STEPS [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

  // Packed to match m_tdata from bit 0 up.
  typedef struct packed {
    logic [swc_pkg::LEN_W-1:0]  len;
    logic [swc_pkg::FREQ_W-1:0] freq;
    logic                       on;
    logic [3:0]                 amp;
  } channel_view_t;

  channel_view_t expected_views[$];

  // Channel state
  logic [6:0]                 sweep_r;
  logic [1:0]                 duty_sel;
  logic [7:0]                 env_r;
  logic [swc_pkg::FREQ_W-1:0] freq;
  logic                       len_en;
  logic [swc_pkg::LEN_W-1:0]  len_cnt;
  int unsigned                period_cnt;
  logic [2:0]                 duty_idx;
  logic [3:0]                 vol;
  logic [2:0]                 env_cnt;
  logic [swc_pkg::FREQ_W-1:0] shadow;
  logic [3:0]                 sweep_cnt;
  logic                       chan_on, sweep_on, env_on, neg_used;
  logic                       prev_len, prev_swp, prev_env;

  function automatic int unsigned reload_of(logic [swc_pkg::FREQ_W-1:0] f);
    return unsigned'((2048 - int'(f)) * swc_pkg::PERIOD_SCALE);
  endfunction

  // Next sweep frequency; an addition past 2047 shuts sweep and channel down.
  task automatic sweep_next(output bit ok, output logic [swc_pkg::FREQ_W-1:0] nxt);
    int unsigned delta, sum;
    delta = 32'(shadow) >> sweep_r[2:0];
    if (sweep_r[3]) begin
      sum = 32'(shadow) - delta;
      neg_used = 1'b1;
    end else begin
      sum = 32'(shadow) + delta;
    end
    nxt = sum[swc_pkg::FREQ_W-1:0];
    ok = (sum <= 2047);
    if (!ok) begin
      sweep_on = 1'b0;
      chan_on  = 1'b0;
    end
  endtask

  task automatic advance_channel(input logic [1:0] cmd, input logic [2:0] sel,
                                 input logic [7:0] d, input logic [2:0] fs);
    bit                         ok;
    logic [swc_pkg::FREQ_W-1:0] nxt;
    logic                       up;
    case (cmd)
      swc_pkg::CMD_WRITE: begin
        case (sel)
          swc_pkg::SEL_SWEEP: begin
            sweep_r = d[6:0];
            if (sweep_r[6:4] == 0 || sweep_r[2:0] == 0 || (!sweep_r[3] && neg_used))
              sweep_on = 1'b0;
          end
          swc_pkg::SEL_DUTY: begin
            duty_sel = d[7:6];
            len_cnt  = swc_pkg::LEN_FULL - {1'b0, d[5:0]};
          end
          swc_pkg::SEL_ENV:     env_r = d;
          swc_pkg::SEL_FREQ_LO: freq[7:0] = d;
          swc_pkg::SEL_FREQ_HI: begin
            freq[10:8] = d[2:0];
            len_en     = d[6];
            if (d[7]) begin
              // trigger
              chan_on    = 1'b1;
              period_cnt = reload_of(freq);
              shadow     = freq;
              sweep_cnt  = {1'b0, sweep_r[6:4]};
              sweep_on   = (sweep_r[6:4] != 0) && (sweep_r[2:0] != 0);
              if (sweep_r[2:0] != 0) sweep_next(ok, nxt);
              neg_used = 1'b0;
              vol      = env_r[7:4];
              env_cnt  = env_r[2:0];
              up       = env_r[3];
              env_on   = (env_cnt != 0) &&
                         !((!up && vol == 0) || (up && vol == swc_pkg::VOL_MAX));
              if (len_cnt == 0) len_cnt = swc_pkg::LEN_FULL;
              if (vol == 0) chan_on = 1'b0;
            end
          end
          default: ;
        endcase
      end
      swc_pkg::CMD_TICK: begin
        if (period_cnt == 0) begin
          duty_idx   = duty_idx + 3'd1;
          period_cnt = reload_of(freq);
        end else begin
          period_cnt = period_cnt - 32'd1;
        end
      end
      swc_pkg::CMD_FRAME: begin
        if (len_en && len_cnt > 0 && !fs[0] && prev_len) begin
          len_cnt = len_cnt - 7'd1;
          if (len_cnt == 0) chan_on = 1'b0;
        end
        prev_len = fs[0];

        if (sweep_on && !fs[1] && prev_swp) begin
          if (sweep_cnt != 0) sweep_cnt = sweep_cnt - 4'd1;
          if (sweep_cnt == 0) begin
            sweep_next(ok, nxt);
            if (ok && sweep_r[2:0] != 0) begin
              shadow = nxt;
              freq   = nxt;
              sweep_next(ok, nxt);
            end
            sweep_cnt = {1'b0, sweep_r[6:4]} + 4'd1;
          end
        end
        prev_swp = fs[1];

        if (env_on && chan_on && !fs[2] && prev_env) begin
          if (env_cnt != 0) env_cnt = env_cnt - 3'd1;
          if (env_cnt == 0) begin
            if (!env_r[3]) begin
              if (vol > 0) vol = vol - 4'd1;
              if (vol == 0) env_on = 1'b0;
            end else begin
              if (vol < swc_pkg::VOL_MAX) vol = vol + 4'd1;
              if (vol == swc_pkg::VOL_MAX) env_on = 1'b0;
            end
            env_cnt = env_r[2:0];
            if (env_cnt == 0) env_on = 1'b0;
          end
        end
        prev_env = fs[2];
      end
      default: ;
    endcase
  endtask

  function automatic channel_view_t channel_view();
    channel_view_t v;
    v.amp  = (chan_on && DUTY_STEPS[duty_sel][duty_idx]) ? vol : 4'd0;
    v.on   = chan_on;
    v.freq = freq;
    v.len  = len_cnt;
    return v;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    errors = errors + 1;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  always @(posedge clk) begin
    channel_view_t want, got;
    if (rst) begin
      sweep_r = '0; duty_sel = '0; env_r = '0; freq = '0; len_en = 1'b0;
      len_cnt = '0; period_cnt = 0; duty_idx = '0; vol = '0; env_cnt = '0;
      shadow = '0; sweep_cnt = '0;
      chan_on = 1'b0; sweep_on = 1'b0; env_on = 1'b0; neg_used = 1'b0;
      prev_len = 1'b0; prev_swp = 1'b0; prev_env = 1'b0;
      expected_views.delete();
      errors   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_channel(s_tuser, s_tdata[2:0], s_tdata[10:3], s_tdata[13:11]);
        expected_views.push_back(channel_view());
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(channel_view_t)-1:0];
        if (expected_views.size() == 0) begin
          errors = errors + 1;
          $display("%0t ns: unexpected result, expected none, got %h", $time, m_tdata);
        end else begin
          want = expected_views.pop_front();
          if (got.amp !== want.amp)
            report_field("amplitude", int'(want.amp), int'(got.amp));
          if (got.on !== want.on)
            report_field("channel_on", int'(want.on), int'(got.on));
          if (got.freq !== want.freq)
            report_field("frequency_now", int'(want.freq), int'(got.freq));
          if (got.len !== want.len)
            report_field("length_left", int'(want.len), int'(got.len));
        end
      end
    end
    pending = expected_views.size();
  end

endmodule

### tb/sv/tb_square_wave_channel_with_sweep_core.sv
// Testbench top for the square-wave channel: stimulus, idling phases and verdict.
module tb_square_wave_channel_with_sweep_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code the block must ignore, and a register select that maps to nothing.
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [2:0] SEL_SPARE = 3'd5;

  localparam int PHASE_ITEMS = 450;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [swc_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [1:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [swc_pkg::OUT_DATA_W-1:0] m_tdata;

  int         errors;
  int         pending;
  int         idle_pct;
  int         stall_pct;
  logic [2:0] frame_pos;

  square_wave_channel_with_sweep_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  swc_channel_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Present one request at a falling edge and hold it until the block takes it.
  // Idle cycles go in front of it at the rate the current phase asks.
  task automatic send(input logic [1:0] c, input logic [2:0] s,
                      input logic [7:0] d, input logic [2:0] f);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {2'b00, f, d, s};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold off until every request has its result back.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly well-formed traffic: register writes biased toward short periods and
  // lengths plus frequent triggers, timer ticks, and a frame counter that mostly
  // counts up so its bits fall regularly. A small share is noise.
  task automatic random_request(output logic [1:0] c, output logic [2:0] s,
                                output logic [7:0] d, output logic [2:0] f);
    int unsigned pick;
    pick = $urandom_range(99);
    c = swc_pkg::CMD_TICK;
    s = 3'($urandom_range(4));
    d = 8'($urandom_range(255));
    f = 3'($urandom_range(7));
    if (pick < 2) begin
      c = 2'($urandom_range(3));
      s = 3'($urandom_range(7));
    end else if (pick < 30) begin
      c = swc_pkg::CMD_WRITE;
      case (s)
        swc_pkg::SEL_DUTY:    if ($urandom_range(1) == 0) d[5:3] = 3'b111;
        swc_pkg::SEL_FREQ_LO: if ($urandom_range(1) == 0) d[7:4] = 4'hF;
        swc_pkg::SEL_FREQ_HI: begin
          if ($urandom_range(3) != 0) d[2:0] = 3'h7;
          d[7] = ($urandom_range(9) < 7);
        end
        default: ;
      endcase
    end else if (pick < 72) begin
      c = swc_pkg::CMD_TICK;
    end else begin
      c = swc_pkg::CMD_FRAME;
      frame_pos = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : frame_pos + 3'd1;
      f = frame_pos;
    end
  endtask

  // Result side: stall at the current phase's rate, decided at each falling edge.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int         idle_tab  [4];
    int         stall_tab [4];
    logic [1:0] c;
    logic [2:0] s;
    logic [7:0] d;
    logic [2:0] f;

    idle_tab  = '{0, 71, 0, 23};
    stall_tab = '{0, 0, 71, 23};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = swc_pkg::CMD_WRITE;
    idle_pct  = 0;
    stall_pct = 0;
    frame_pos = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: length of one runs out after a single falling edge.
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_SWEEP, 8'h00, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_DUTY, 8'hFF, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_ENV, 8'hF0, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_LO, 8'hFF, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_HI, 8'hC7, 3'd0);
    // Shortest period: the duty position moves after a handful of ticks.
    repeat (6) send(swc_pkg::CMD_TICK, swc_pkg::SEL_SWEEP, 8'h00, 3'd7);
    send(swc_pkg::CMD_FRAME, swc_pkg::SEL_SWEEP, 8'h00, 3'd1);
    send(swc_pkg::CMD_FRAME, swc_pkg::SEL_SWEEP, 8'h00, 3'd0);
    // Trigger at top frequency with an additive sweep: overflow shuts it down,
    // and the exhausted length reloads to full.
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_SWEEP, 8'h11, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_ENV, 8'hF8, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_HI, 8'h87, 3'd0);
    // Subtracting sweep, one step on a falling bit 1, then negate cleared.
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_SWEEP, 8'h19, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_LO, 8'h00, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_HI, 8'h84, 3'd0);
    send(swc_pkg::CMD_FRAME, swc_pkg::SEL_SWEEP, 8'h00, 3'd2);
    send(swc_pkg::CMD_FRAME, swc_pkg::SEL_SWEEP, 8'h00, 3'd4);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_SWEEP, 8'h11, 3'd0);
    // Envelope stepping down on a falling bit 2.
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_ENV, 8'h91, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_HI, 8'h80, 3'd0);
    send(swc_pkg::CMD_FRAME, swc_pkg::SEL_SWEEP, 8'h00, 3'd0);
    // Ignored requests, then a trigger with zero volume.
    send(swc_pkg::CMD_WRITE, SEL_SPARE, 8'hFF, 3'd7);
    send(CMD_NONE, swc_pkg::SEL_SWEEP, 8'hFF, 3'd7);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_ENV, 8'h00, 3'd0);
    send(swc_pkg::CMD_WRITE, swc_pkg::SEL_FREQ_HI, 8'h80, 3'd0);
    drain();

    // Random phases; each one drains completely before the next starts.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      repeat (PHASE_ITEMS) begin
        random_request(c, s, d, f);
        send(c, s, d, f);
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
